/* src/adpcm4_pkg.sv */
// shared types, constants and lookup tables for the 4-bit adpcm encoder
package adpcm4_pkg;

	localparam int SAMPLE_W = 8;
	localparam int CODE_W = 4;
	localparam int MAG_W = 3;
	localparam int STEP_W = 2;
	localparam int RES_W = 4;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [SAMPLE_W-1:0] PRED_RESET = 8'd128;
	localparam logic [STEP_W-1:0] STEP_MAX = 2'd3;
	localparam logic [MAG_W-1:0] MAG_MAX = 3'd7;

	// one queue slot as seen by the back end
	typedef struct packed {
		logic valid;
		logic [SAMPLE_W-1:0] sample;
	} sample_chan_t;

	// predictor delta, indexed by {step, sign, magnitude}
	localparam logic signed [7:0] SCALE_TAB [64] = '{
		8'sd0, 8'sd1, 8'sd2, 8'sd3, 8'sd4, 8'sd5, 8'sd6, 8'sd7,
		8'sd0, -8'sd1, -8'sd2, -8'sd3, -8'sd4, -8'sd5, -8'sd6, -8'sd7,
		8'sd1, 8'sd3, 8'sd5, 8'sd7, 8'sd9, 8'sd11, 8'sd13, 8'sd15,
		-8'sd1, -8'sd3, -8'sd5, -8'sd7, -8'sd9, -8'sd11, -8'sd13, -8'sd15,
		8'sd2, 8'sd6, 8'sd10, 8'sd14, 8'sd18, 8'sd22, 8'sd26, 8'sd30,
		-8'sd2, -8'sd6, -8'sd10, -8'sd14, -8'sd18, -8'sd22, -8'sd26, -8'sd30,
		8'sd4, 8'sd12, 8'sd20, 8'sd28, 8'sd36, 8'sd44, 8'sd52, 8'sd60,
		-8'sd4, -8'sd12, -8'sd20, -8'sd28, -8'sd36, -8'sd44, -8'sd52, -8'sd60
	};

	// step index delta, indexed by {step, magnitude}
	localparam logic signed [1:0] ADJUST_TAB [32] = '{
		2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd1, 2'sd1, 2'sd1,
		-2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd1, 2'sd1, 2'sd1,
		-2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd1, 2'sd1, 2'sd1,
		-2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd0
	};

endpackage

/* src/adpcm4_queue.sv */
// front end: accepts samples into a short fifo ahead of the encoder core
module adpcm4_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic sample_valid,
	output logic sample_stall,
	input  logic [adpcm4_pkg::SAMPLE_W-1:0] sample,
	output adpcm4_pkg::sample_chan_t head,
	input  logic pop
);

	localparam int PtrW = (adpcm4_pkg::QUEUE_DEPTH > 1) ? $clog2(adpcm4_pkg::QUEUE_DEPTH) : 1;
	localparam int CntW = $clog2(adpcm4_pkg::QUEUE_DEPTH + 1);
	localparam logic [CntW-1:0] Full = CntW'(adpcm4_pkg::QUEUE_DEPTH);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(adpcm4_pkg::QUEUE_DEPTH - 1);

	logic [adpcm4_pkg::SAMPLE_W-1:0] slot_q [adpcm4_pkg::QUEUE_DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic push;
	logic do_pop;

	assign sample_stall = (count_q == Full);
	assign push = sample_valid && !sample_stall;
	assign do_pop = pop && head.valid;
	assign head.valid = (count_q != '0);
	assign head.sample = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= Full)
		else $error("queue fill above depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("push without pop did not grow the fill");

	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !push) |=> count_q == $past(count_q) - 1'b1)
		else $error("pop without push did not shrink the fill");

endmodule

/* src/adpcm4_core.sv */
// back end: predictor, step and residue update with the registered code output
module adpcm4_core (
	input  logic clk,
	input  logic arst_n,
	input  adpcm4_pkg::sample_chan_t head,
	output logic pop,
	output logic code_valid,
	input  logic code_stall,
	output logic [adpcm4_pkg::CODE_W-1:0] code
);

	logic [adpcm4_pkg::SAMPLE_W-1:0] pred_q;
	logic [adpcm4_pkg::STEP_W-1:0] step_q;
	logic [adpcm4_pkg::RES_W-1:0] res_q;
	logic [adpcm4_pkg::CODE_W-1:0] code_q;
	logic valid_q;

	logic take;
	logic [7:0] diff8;
	logic signed [9:0] dsum;
	logic [2:0] shamt;
	logic signed [9:0] shifted;
	logic signed [9:0] absval;
	logic neg;
	logic [adpcm4_pkg::MAG_W-1:0] mag;
	logic [adpcm4_pkg::RES_W-1:0] res_next;
	logic signed [7:0] scale;
	logic signed [1:0] adj;
	logic signed [9:0] pred_sum;
	logic signed [3:0] step_sum;
	logic [adpcm4_pkg::SAMPLE_W-1:0] pred_next;
	logic [adpcm4_pkg::STEP_W-1:0] step_next;

	// output register frees up when empty or being drained
	assign take = head.valid && (!valid_q || !code_stall);
	assign pop = take;
	assign code_valid = valid_q;
	assign code = code_q;

	always_comb begin
		diff8 = head.sample - pred_q;
		dsum = $signed({diff8[7], diff8, 1'b0});
		if (step_q != adpcm4_pkg::STEP_MAX) begin
			dsum = dsum + $signed({6'b0, res_q});
		end
		shamt = {1'b0, step_q} + 3'd1;
		res_next = dsum[3:0] & ~(4'hF << shamt);
		shifted = dsum >>> shamt;
		neg = shifted[9];
		absval = neg ? -shifted : shifted;
		mag = (absval > 10'sd7) ? adpcm4_pkg::MAG_MAX : absval[2:0];
		scale = adpcm4_pkg::SCALE_TAB[{step_q, neg, mag}];
		adj = adpcm4_pkg::ADJUST_TAB[{step_q, mag}];
		pred_sum = $signed({2'b0, pred_q}) + 10'(scale);
		priority if (pred_sum < 10'sd0) begin
			pred_next = '0;
		end else if (pred_sum > 10'sd255) begin
			pred_next = 8'hFF;
		end else begin
			pred_next = pred_sum[7:0];
		end
		step_sum = $signed({2'b0, step_q}) + 4'(adj);
		priority if (step_sum < 4'sd0) begin
			step_next = '0;
		end else if (step_sum > 4'sd3) begin
			step_next = adpcm4_pkg::STEP_MAX;
		end else begin
			step_next = step_sum[1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			code_q <= {neg, mag};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pred_q <= adpcm4_pkg::PRED_RESET;
			step_q <= '0;
			res_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (take) begin
				pred_q <= pred_next;
				step_q <= step_next;
				res_q <= res_next;
			end
			if (take) begin
				valid_q <= 1'b1;
			end else if (!code_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> ($stable(pred_q) && $stable(step_q) && $stable(res_q)))
		else $error("encoder state moved without an item");

	a_zero_mag_pred: assert property (@(posedge clk) disable iff (!arst_n)
		(take && mag == '0 && step_q == '0) |=> $stable(pred_q))
		else $error("zero magnitude at step zero moved the predictor");

	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (code_valid && code == $past({neg, mag})))
		else $error("taken item not presented at the output");

endmodule

/* src/adpcm_4bit_encoder_unit.sv */
// top level of the 4-bit adpcm encoder: input fifo and encoder core
//
//  channel | dir | handshake                   | payload
//  sample  | in  | sample_valid / sample_stall | sample[7:0], unsigned pcm
//  code    | out | code_valid / code_stall     | code[3:0], bit 3 sign, 2..0 magnitude
//
// one item per cycle sustained while code_stall is low; a sample passes the fifo slot, then the output register
// the rate is set by the predictor/step/residue feedback loop, which updates on every taken item
// reset: predictor 128, step index 0, residue 0, fifo and output register empty
// a stalled output holds its code; the two-entry fifo keeps taking samples until full
// sample_stall rises only when the fifo is full
module adpcm_4bit_encoder_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic sample_valid,
	output logic sample_stall,
	input  logic [adpcm4_pkg::SAMPLE_W-1:0] sample,
	output logic code_valid,
	input  logic code_stall,
	output logic [adpcm4_pkg::CODE_W-1:0] code
);

	// head of the fifo as seen by the core
	adpcm4_pkg::sample_chan_t head;
	// core takes the head item this cycle
	logic pop;

	// front: sample fifo decouples input acceptance from encoding
	adpcm4_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.head(head),
		.pop(pop)
	);

	// back: encoder state update and registered code output
	adpcm4_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.pop(pop),
		.code_valid(code_valid),
		.code_stall(code_stall),
		.code(code)
	);

endmodule

/* tb/adpcm_code_checker.sv */
// checker for the adpcm encoder: tracks both channels, predicts codes and compares them
module adpcm_code_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic sample_valid,
	input  logic sample_stall,
	input  logic [adpcm4_pkg::SAMPLE_W-1:0] sample,
	input  logic code_valid,
	input  logic code_stall,
	input  logic [adpcm4_pkg::CODE_W-1:0] code,
	output int errors,
	output int pending,
	output int codes_checked,
	output int top_step_items
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PCM_TOP = 255;

	// encoder state as the checker sees it
	logic [adpcm4_pkg::SAMPLE_W-1:0] pred_q;
	logic [adpcm4_pkg::STEP_W-1:0] step_q;
	logic [adpcm4_pkg::RES_W-1:0] resid_q;
	logic [adpcm4_pkg::CODE_W-1:0] expected_codes [$];

	task automatic report_mismatch(input string what);
		$display("%0t checker: %s", $realtime, what);
		errors++;
	endtask

	// one encoder step: returns the code and advances predictor, step and residue
	function automatic logic [adpcm4_pkg::CODE_W-1:0] encode_sample(
		input logic [adpcm4_pkg::SAMPLE_W-1:0] smp);
		logic [adpcm4_pkg::SAMPLE_W-1:0] delta;
		logic neg;
		int s, d, mag, move, npred, nstep;
		s = int'(step_q);
		delta = smp - pred_q;
		d = int'($signed(delta)) * 2;
		if (step_q != adpcm4_pkg::STEP_MAX)
			d += int'(resid_q);
		resid_q = adpcm4_pkg::RES_W'(d & ((1 << (s + 1)) - 1));
		d = d >>> (s + 1);
		neg = d < 0;
		mag = neg ? -d : d;
		if (mag > int'(adpcm4_pkg::MAG_MAX))
			mag = int'(adpcm4_pkg::MAG_MAX);
		// step 0 moves by the magnitude, higher steps by (2m+1) scaled up
		move = (s == 0) ? mag : (2 * mag + 1) << (s - 1);
		npred = int'(pred_q) + (neg ? -move : move);
		if (npred < 0)
			npred = 0;
		else if (npred > PCM_TOP)
			npred = PCM_TOP;
		pred_q = npred[adpcm4_pkg::SAMPLE_W-1:0];
		// sign plays no part in the step adjust
		nstep = s;
		if (mag == 0 && s != 0)
			nstep = s - 1;
		else if (mag >= 5 && s != int'(adpcm4_pkg::STEP_MAX))
			nstep = s + 1;
		step_q = nstep[adpcm4_pkg::STEP_W-1:0];
		return {neg, mag[adpcm4_pkg::MAG_W-1:0]};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [adpcm4_pkg::CODE_W-1:0] want;
		if (!arst_n) begin
			pred_q = adpcm4_pkg::PRED_RESET;
			step_q = '0;
			resid_q = '0;
			expected_codes.delete();
			pending = 0;
		end else begin
			if (code_valid && !code_stall) begin
				if (expected_codes.size() == 0) begin
					report_mismatch($sformatf("code %0d with no sample waiting", code));
				end else begin
					want = expected_codes.pop_front();
					codes_checked++;
					if (code !== want)
						report_mismatch($sformatf("code %0d, expected %0d", code, want));
				end
			end
			if (sample_valid && !sample_stall) begin
				if (step_q == adpcm4_pkg::STEP_MAX)
					top_step_items++;
				expected_codes.push_back(encode_sample(sample));
			end
			pending = expected_codes.size();
		end
	end

	initial begin
		errors = 0;
		pending = 0;
		codes_checked = 0;
		top_step_items = 0;
	end

endmodule

/* tb/tb.sv */
// testbench top for the 4-bit adpcm encoder: stimulus, handshake idling and verdict
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1300;
	localparam int CALM_FROM = 500;
	localparam int CALM_TO = 800;
	localparam int IDLE_PCT = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	logic [adpcm4_pkg::SAMPLE_W-1:0] sample = '0;
	logic code_valid;
	logic code_stall = 1'b0;
	logic [adpcm4_pkg::CODE_W-1:0] code;

	// while set, neither side inserts gaps or stalls
	logic calm = 1'b0;

	int errors, pending, codes_checked, top_step_items;
	int samples_sent = 0;

	always #5 clk = ~clk;

	adpcm_4bit_encoder_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.code_valid(code_valid),
		.code_stall(code_stall),
		.code(code)
	);

	adpcm_code_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.code_valid(code_valid),
		.code_stall(code_stall),
		.code(code),
		.errors(errors),
		.pending(pending),
		.codes_checked(codes_checked),
		.top_step_items(top_step_items)
	);

	// receiver back-pressure: random stalls, none in the calm stretch
	always @(negedge clk) begin
		code_stall <= !calm && $urandom_range(99) < IDLE_PCT;
	end

	// called at a falling edge; returns at the falling edge after the item is taken
	task automatic send_sample(input logic [adpcm4_pkg::SAMPLE_W-1:0] v);
		// random gaps ahead of the item, payload is junk while valid is low
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			sample_valid <= 1'b0;
			sample <= adpcm4_pkg::SAMPLE_W'($urandom);
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		sample <= v;
		// hold the item until a rising edge sees no stall
		do
			@(posedge clk);
		while (sample_stall);
		samples_sent++;
		@(negedge clk);
	endtask

	initial begin
		// directed opening: steady midpoint, full-scale swings to push the step
		// index to its top, then settling so the step falls back and a residue
		// kept at the top step gets added in full, plus near-extreme values
		logic [adpcm4_pkg::SAMPLE_W-1:0] opening [22] = '{
			8'd128, 8'd128, 8'd129, 8'd127, 8'd255, 8'd255, 8'd255, 8'd0,
			8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd128, 8'd128, 8'd128,
			8'd128, 8'd130, 8'd126, 8'd1, 8'd254, 8'd128
		};
		int walk, n;
		logic [adpcm4_pkg::SAMPLE_W-1:0] v;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (opening[i])
			send_sample(opening[i]);

		// random part: mostly a slow random walk, which lets the step index
		// drift both ways, with occasional jumps and fully random samples
		walk = 128;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			calm = (n >= CALM_FROM && n < CALM_TO);
			case ($urandom_range(9))
				0, 1, 2: begin
					v = adpcm4_pkg::SAMPLE_W'($urandom);
				end
				3: begin
					walk = $urandom_range(255);
					v = walk[adpcm4_pkg::SAMPLE_W-1:0];
				end
				default: begin
					walk += int'($urandom_range(16)) - 8;
					if (walk < 0)
						walk = 0;
					else if (walk > 255)
						walk = 255;
					v = walk[adpcm4_pkg::SAMPLE_W-1:0];
				end
			endcase
			send_sample(v);
		end
		calm = 1'b0;
		sample_valid <= 1'b0;

		// drain: every predicted code has to come out, then the bench idles before the verdict
		while (pending != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);

		$display("tb: %0d samples sent, %0d codes compared", samples_sent, codes_checked);
		$display("tb: %0d samples encoded at the top step index, %0d mismatches",
			top_step_items, errors);
		if (errors == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#1ms;
		$display("tb: errors");
		$finish;
	end

endmodule
